// File: rtl/anchor_box_decode_best_crop_top_defines.svh
// assertion macros shared by the rtl files abdbc_fifo and abdbc_decode
`ifndef ANCHOR_BOX_DECODE_BEST_CROP_TOP_DEFINES_SVH
`define ANCHOR_BOX_DECODE_BEST_CROP_TOP_DEFINES_SVH

`ifndef SYNTH
`define ABDBC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ABDBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ABDBC_ASSERT(label, clk, rst_n, prop, msg)
`define ABDBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/abdbc_pkg.sv
`default_nettype none

package abdbc_pkg;

	localparam int ANCHOR_COUNT  = 896;
	localparam int FIRST_LAYER   = 512;
	localparam int IDX_W         = 10;
	localparam int FRACTION_BITS = 8;
	localparam int FIFO_DEPTH    = 4;
	localparam int PTR_W         = $clog2(FIFO_DEPTH);

	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH     = 3'd0,
		REG_IMAGE_HEIGHT    = 3'd1,
		REG_FRAME_WIDTH     = 3'd2,
		REG_FRAME_HEIGHT    = 3'd3,
		REG_SCORE_THRESHOLD = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [11:0]        image_width;
		logic [11:0]        image_height;
		logic [11:0]        frame_width;
		logic [11:0]        frame_height;
		logic signed [15:0] score_threshold;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] score;
		logic signed [19:0] offset_y;
		logic signed [19:0] offset_x;
		logic signed [19:0] box_height;
		logic signed [19:0] box_width;
		logic               last;
		logic               layer;
		logic [3:0]         cell_x;
		logic [3:0]         cell_y;
	} item_t;

	typedef struct packed {
		logic valid;
		logic found;
	} crop_ctrl_t;

	// floor(v / 6) for v below 384
	function automatic logic [5:0] div6(input logic [8:0] v);
		logic [17:0] p;
		p = 18'(v) * 18'd171;
		return p[15:10];
	endfunction

endpackage

`default_nettype wire

// File: rtl/abdbc_front.sv
`default_nettype none

module abdbc_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [95:0]         s_tdata,
	input  wire logic                s_tlast,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [15:0]         cfg_data,
	output abdbc_pkg::cfg_t          cfg,
	output logic                     push,
	output abdbc_pkg::item_t         push_item,
	input  wire logic                fifo_full
);

	logic [abdbc_pkg::IDX_W-1:0] anchor_q;
	abdbc_pkg::cfg_t             cfg_q;
	logic                        layer;
	logic [8:0]                  rel;
	logic [5:0]                  cell6;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;
	assign s_tready  = !fifo_full;
	assign push      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width     <= 12'd640;
			cfg_q.image_height    <= 12'd480;
			cfg_q.frame_width     <= 12'd640;
			cfg_q.frame_height    <= 12'd480;
			cfg_q.score_threshold <= 16'sd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				abdbc_pkg::REG_IMAGE_WIDTH:     cfg_q.image_width     <= cfg_data[11:0];
				abdbc_pkg::REG_IMAGE_HEIGHT:    cfg_q.image_height    <= cfg_data[11:0];
				abdbc_pkg::REG_FRAME_WIDTH:     cfg_q.frame_width     <= cfg_data[11:0];
				abdbc_pkg::REG_FRAME_HEIGHT:    cfg_q.frame_height    <= cfg_data[11:0];
				abdbc_pkg::REG_SCORE_THRESHOLD: cfg_q.score_threshold <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_q <= '0;
		end else if (push) begin
			if (s_tlast || anchor_q == abdbc_pkg::IDX_W'(abdbc_pkg::ANCHOR_COUNT - 1)) begin
				anchor_q <= '0;
			end else begin
				anchor_q <= anchor_q + abdbc_pkg::IDX_W'(1);
			end
		end
	end

	// anchor position: 16x16 grid with 2 per cell, then 8x8 grid with 6 per cell
	assign layer = anchor_q >= abdbc_pkg::IDX_W'(abdbc_pkg::FIRST_LAYER);
	assign rel   = 9'(anchor_q - abdbc_pkg::IDX_W'(abdbc_pkg::FIRST_LAYER));
	assign cell6 = abdbc_pkg::div6(rel);

	always_comb begin
		push_item.score      = $signed(s_tdata[15:0]);
		push_item.offset_y   = $signed(s_tdata[35:16]);
		push_item.offset_x   = $signed(s_tdata[55:36]);
		push_item.box_height = $signed(s_tdata[75:56]);
		push_item.box_width  = $signed(s_tdata[95:76]);
		push_item.last       = s_tlast;
		push_item.layer      = layer;
		if (layer) begin
			push_item.cell_x = {1'b0, cell6[2:0]};
			push_item.cell_y = {1'b0, cell6[5:3]};
		end else begin
			push_item.cell_x = anchor_q[4:1];
			push_item.cell_y = anchor_q[8:5];
		end
	end

endmodule

`default_nettype wire

// File: rtl/abdbc_fifo.sv
`default_nettype none

`include "anchor_box_decode_best_crop_top_defines.svh"

module abdbc_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire abdbc_pkg::item_t push_item,
	output logic                  full,
	input  wire logic             pop,
	output abdbc_pkg::item_t      pop_item,
	output logic                  empty
);

	abdbc_pkg::item_t              mem_q [abdbc_pkg::FIFO_DEPTH];
	logic [abdbc_pkg::PTR_W-1:0]   wr_q;
	logic [abdbc_pkg::PTR_W-1:0]   rd_q;
	logic [abdbc_pkg::PTR_W:0]     cnt_q;

	assign full     = cnt_q == (abdbc_pkg::PTR_W + 1)'(abdbc_pkg::FIFO_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + abdbc_pkg::PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + abdbc_pkg::PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (abdbc_pkg::PTR_W + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (abdbc_pkg::PTR_W + 1)'(1);
			end
		end
	end

	`ABDBC_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= (abdbc_pkg::PTR_W + 1)'(abdbc_pkg::FIFO_DEPTH), "queue count over depth")
	`ABDBC_ASSERT(a_no_underflow, clk, arst_n, !(pop && empty), "pop from empty queue")
	`ABDBC_ASSERT_NEXT(a_cnt_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "queue count did not grow")

endmodule

`default_nettype wire

// File: rtl/abdbc_decode.sv
`default_nettype none

`include "anchor_box_decode_best_crop_top_defines.svh"

module abdbc_decode #(
	parameter int FRACTION_BITS = abdbc_pkg::FRACTION_BITS,
	parameter int DW            = 26 + abdbc_pkg::FRACTION_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire abdbc_pkg::cfg_t       cfg,
	input  wire logic                  in_valid,
	input  wire abdbc_pkg::item_t      in_item,
	output abdbc_pkg::crop_ctrl_t      ctrl_s2,
	output logic signed [DW-1:0]       left_s2,
	output logic signed [DW-1:0]       top_s2,
	output logic signed [DW-1:0]       width_s2,
	output logic signed [DW-1:0]       height_s2
);

	localparam int SW = FRACTION_BITS + 20;
	localparam int XW = (SW > 33) ? SW : 33;
	localparam logic signed [XW-1:0] MAXV = XW'(8388607);
	localparam logic signed [XW-1:0] MINV = -MAXV - XW'(1);

	function automatic logic signed [23:0] sat24(input logic signed [XW-1:0] v);
		if (v > MAXV) begin
			return 24'sh7FFFFF;
		end else if (v < MINV) begin
			return -24'sh7FFFFF - 24'sd1;
		end
		return v[23:0];
	endfunction

	// stage 1: anchor centre and size products
	logic                 v_s1;
	logic signed [15:0]   score_s1;
	logic signed [19:0]   oy_s1, ox_s1, bh_s1, bw_s1;
	logic                 last_s1;
	logic [16:0]          ax_s1, ay_s1;
	logic signed [32:0]   wp_s1, hp_s1;

	logic [11:0]          sx, sy;
	logic [16:0]          ax_c, ay_c;
	logic signed [32:0]   wp_c, hp_c;

	assign sx   = in_item.layer ? (cfg.image_width >> 3) : (cfg.image_width >> 4);
	assign sy   = in_item.layer ? (cfg.image_height >> 3) : (cfg.image_height >> 4);
	assign ax_c = 17'(sx) * 17'({in_item.cell_x, 1'b1});
	assign ay_c = 17'(sy) * 17'({in_item.cell_y, 1'b1});
	assign wp_c = 33'(in_item.box_width) * 33'($signed({1'b0, cfg.image_width}));
	assign hp_c = 33'(in_item.box_height) * 33'($signed({1'b0, cfg.image_height}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			score_s1 <= in_item.score;
			oy_s1    <= in_item.offset_y;
			ox_s1    <= in_item.offset_x;
			bh_s1    <= in_item.box_height;
			bw_s1    <= in_item.box_width;
			last_s1  <= in_item.last;
			ax_s1    <= ax_c;
			ay_s1    <= ay_c;
			wp_s1    <= wp_c;
			hp_s1    <= hp_c;
		end
	end

	// stage 2: box decode and running best
	logic signed [XW-1:0] left_w, top_w, wid_w, hgt_w;
	logic signed [23:0]   left_n, top_n, wid_n, hgt_n;
	logic                 pass;
	logic                 step;
	logic                 fin_valid;

	logic                 best_valid_q;
	logic signed [15:0]   best_score_q;
	logic signed [23:0]   best_left_q, best_top_q, best_width_q, best_height_q;

	always_comb begin
		left_w = XW'(ox_s1) + $signed(XW'(ax_s1) << (FRACTION_BITS - 1)) - (XW'(bw_s1) <<< 1);
		top_w  = XW'(oy_s1) + $signed(XW'(ay_s1) << (FRACTION_BITS - 1)) - (XW'(bh_s1) <<< 1);
		wid_w  = XW'(wp_s1) >>> 7;
		hgt_w  = XW'(hp_s1) >>> 7;
		left_n = sat24(left_w);
		top_n  = sat24(top_w);
		wid_n  = sat24(wid_w);
		hgt_n  = sat24(hgt_w);
	end

	assign step      = en && v_s1;
	assign pass      = (score_s1 > cfg.score_threshold)
		&& (!best_valid_q || score_s1 > best_score_q);
	assign fin_valid = pass || best_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q <= 1'b0;
			best_score_q <= '0;
		end else if (step) begin
			if (last_s1) begin
				best_valid_q <= 1'b0;
				best_score_q <= '0;
			end else if (pass) begin
				best_valid_q <= 1'b1;
				best_score_q <= score_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && pass) begin
			best_left_q   <= left_n;
			best_top_q    <= top_n;
			best_width_q  <= wid_n;
			best_height_q <= hgt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else if (en) begin
			ctrl_s2.valid <= v_s1 && last_s1;
			ctrl_s2.found <= fin_valid;
		end
	end

	// output box: this anchor's box if it passed, else the running best, else a default box when nothing passed
	always_ff @(posedge clk) begin
		if (en) begin
			if (pass) begin
				left_s2   <= DW'(left_n);
				top_s2    <= DW'(top_n);
				width_s2  <= DW'(wid_n);
				height_s2 <= DW'(hgt_n);
			end else if (best_valid_q) begin
				left_s2   <= DW'(best_left_q);
				top_s2    <= DW'(best_top_q);
				width_s2  <= DW'(best_width_q);
				height_s2 <= DW'(best_height_q);
			end else begin
				left_s2   <= '0;
				top_s2    <= '0;
				width_s2  <= DW'(192) <<< FRACTION_BITS;
				height_s2 <= DW'(192) <<< FRACTION_BITS;
			end
		end
	end

	`ABDBC_ASSERT_NEXT(a_clear_on_last, clk, arst_n, step && last_s1, !best_valid_q, "best box not cleared after last anchor")

endmodule

`default_nettype wire

// File: rtl/abdbc_crop.sv
`default_nettype none

module abdbc_crop #(
	parameter int FRACTION_BITS = abdbc_pkg::FRACTION_BITS,
	parameter int DW            = 26 + abdbc_pkg::FRACTION_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	output logic                       en,
	input  wire abdbc_pkg::cfg_t       cfg,
	input  wire abdbc_pkg::crop_ctrl_t ctrl_s2,
	input  wire logic signed [DW-1:0]  left_s2,
	input  wire logic signed [DW-1:0]  top_s2,
	input  wire logic signed [DW-1:0]  width_s2,
	input  wire logic signed [DW-1:0]  height_s2,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [55:0]                out_data,
	output logic                       out_found
);

	localparam int TW = DW - FRACTION_BITS;

	function automatic logic signed [TW-1:0] trunc_fix(input logic signed [DW-1:0] v);
		logic [DW-1:0] mag;
		logic [DW-1:0] sh;
		mag = v[DW-1] ? DW'(-v) : DW'(v);
		sh  = mag >> FRACTION_BITS;
		return v[DW-1] ? -TW'(sh) : TW'(sh);
	endfunction

	function automatic logic [13:0] sat14(input logic signed [TW:0] v);
		if (v > (TW + 1)'(8191)) begin
			return 14'h1FFF;
		end else if (v < -(TW + 1)'(8192)) begin
			return 14'h2000;
		end
		return v[13:0];
	endfunction

	logic                 out_valid_q;
	logic [55:0]          out_data_q;
	logic                 out_found_q;

	assign en        = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_found = out_found_q;

	// margins, frame size / 10 by reciprocal
	logic [27:0] mw_p, mh_p;
	logic [8:0]  mw_q, mh_q;

	assign mw_p = 28'(cfg.frame_width) * 28'd52429;
	assign mh_p = 28'(cfg.frame_height) * 28'd52429;

	always_ff @(posedge clk) begin
		mw_q <= mw_p[27:19];
		mh_q <= mh_p[27:19];
	end

	// stage 3: widen by margin
	abdbc_pkg::crop_ctrl_t ctrl_s3;
	logic signed [DW-1:0]  dx_s3, dy_s3, dw_s3, dh_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else if (en) begin
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s3 <= left_s2 - $signed(DW'(mw_q) << FRACTION_BITS);
			dy_s3 <= top_s2 - $signed(DW'(mh_q) << FRACTION_BITS);
			dw_s3 <= width_s2 + $signed(DW'(mw_q) << (FRACTION_BITS + 1));
			dh_s3 <= height_s2 + $signed(DW'(mh_q) << (FRACTION_BITS + 1));
		end
	end

	// stage 4: truncate to pixels, clamp origin at zero
	abdbc_pkg::crop_ctrl_t ctrl_s4;
	logic signed [TW-1:0]  x_s4, y_s4, w_s4, h_s4;
	logic signed [TW-1:0]  tx, ty;

	assign tx = trunc_fix(dx_s3);
	assign ty = trunc_fix(dy_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s4 <= '0;
		end else if (en) begin
			ctrl_s4 <= ctrl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s4 <= tx[TW-1] ? '0 : tx;
			y_s4 <= ty[TW-1] ? '0 : ty;
			w_s4 <= trunc_fix(dw_s3);
			h_s4 <= trunc_fix(dh_s3);
		end
	end

	// clip to frame edge and register the result
	logic signed [TW:0] fw, fh, x_e, y_e, w_e, h_e, w_c, h_c;

	always_comb begin
		fw  = (TW + 1)'($signed({1'b0, cfg.frame_width}));
		fh  = (TW + 1)'($signed({1'b0, cfg.frame_height}));
		x_e = (TW + 1)'(x_s4);
		y_e = (TW + 1)'(y_s4);
		w_e = (TW + 1)'(w_s4);
		h_e = (TW + 1)'(h_s4);
		w_c = (w_e + x_e > fw) ? fw - x_e : w_e;
		h_c = (h_e + y_e > fh) ? fh - y_e : h_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctrl_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q  <= {sat14(h_c), sat14(w_c), sat14(y_e), sat14(x_e)};
			out_found_q <= ctrl_s4.found;
		end
	end

endmodule

`default_nettype wire

// File: rtl/anchor_box_decode_best_crop_top.sv
// Anchor decoder with best-box pick and crop output. One anchor is taken per clock on the
// input stream while the queue is not full (score, offsets, size, tlast on the final anchor
// of a frame); the anchor position comes from an internal counter. A four-entry queue sits
// between the input side and the decode pipeline; while a crop result waits on the output
// the pipeline holds, the queue fills up to its four entries and then the input stalls.
// Sustained rate is one anchor per cycle while the output does not hold the pipeline; the
// crop result is offered once its last anchor has left the queue and passed the stage 1 to
// stage 4 and output registers. Configuration is written over its own channel while no
// frame is in flight; the user must keep to this, the block itself does not enforce it.
`default_nettype none

module anchor_box_decode_best_crop_top #(
	parameter int FRACTION_BITS = abdbc_pkg::FRACTION_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,   // score_logit, offset_y, offset_x, box_height, box_width
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // crop_x, crop_y, crop_width, crop_height
	output logic             m_tuser,   // face_found
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int DW = 26 + FRACTION_BITS;

	abdbc_pkg::cfg_t       cfg;
	abdbc_pkg::item_t      push_item;
	abdbc_pkg::item_t      pop_item;
	abdbc_pkg::crop_ctrl_t ctrl_s2;
	logic                  push, pop, full, empty, en;
	logic signed [DW-1:0]  left_s2, top_s2, width_s2, height_s2;

	assign pop = en && !empty;

	abdbc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.push      (push),
		.push_item (push_item),
		.fifo_full (full)
	);

	abdbc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	abdbc_decode #(
		.FRACTION_BITS (FRACTION_BITS),
		.DW            (DW)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg),
		.in_valid  (pop),
		.in_item   (pop_item),
		.ctrl_s2   (ctrl_s2),
		.left_s2   (left_s2),
		.top_s2    (top_s2),
		.width_s2  (width_s2),
		.height_s2 (height_s2)
	);

	abdbc_crop #(
		.FRACTION_BITS (FRACTION_BITS),
		.DW            (DW)
	) u_crop (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg),
		.ctrl_s2   (ctrl_s2),
		.left_s2   (left_s2),
		.top_s2    (top_s2),
		.width_s2  (width_s2),
		.height_s2 (height_s2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_found (m_tuser)
	);

endmodule

`default_nettype wire

// File: sim/anchor_crop_checker.sv
`timescale 1ns / 100ps

module anchor_crop_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [95:0] s_tdata,   // score_logit, offset_y, offset_x, box_height, box_width
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,   // crop_x, crop_y, crop_width, crop_height
	input  logic        m_tuser,   // face_found
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatch_count,
	output int          crops_seen
);

	localparam int HI_GRID      = 16;
	localparam int HI_PER_CELL  = 2;
	localparam int LO_GRID      = 8;
	localparam int LO_PER_CELL  = 6;
	localparam int SCALE_SHIFT  = 7;
	localparam int MARGIN_DIV   = 10;
	localparam int DEFAULT_SIDE = 192;
	localparam int BOX_W        = 24;
	localparam int CROP_W       = 14;

	typedef struct {
		longint x;
		longint y;
		longint w;
		longint h;
		logic   found;
	} crop_t;

	crop_t crop_queue[$];

	logic [11:0]        img_w, img_h, frm_w, frm_h;
	logic signed [15:0] logit_floor;

	int     anchor_pos;
	logic   best_seen;
	longint best_logit, best_l, best_t, best_w, best_h;

	function automatic longint saturate(input longint v, input int w);
		longint hi, lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic longint trunc_px(input longint v);
		return v >= 0 ? (v >>> abdbc_pkg::FRACTION_BITS)
			: -((-v) >>> abdbc_pkg::FRACTION_BITS);
	endfunction

	task automatic clear_best();
		anchor_pos = 0;
		best_seen  = 1'b0;
		best_logit = 0;
		best_l     = 0;
		best_t     = 0;
		best_w     = 0;
		best_h     = 0;
	endtask

	task automatic apply_reg(input logic [2:0] idx, input logic [15:0] data);
		case (idx)
			abdbc_pkg::REG_IMAGE_WIDTH:     img_w = data[11:0];
			abdbc_pkg::REG_IMAGE_HEIGHT:    img_h = data[11:0];
			abdbc_pkg::REG_FRAME_WIDTH:     frm_w = data[11:0];
			abdbc_pkg::REG_FRAME_HEIGHT:    frm_h = data[11:0];
			abdbc_pkg::REG_SCORE_THRESHOLD: logit_floor = data;
			default: ;
		endcase
	endtask

	task automatic absorb_anchor(input logic [95:0] d, input logic is_last);
		longint logit, oy, ox, bh, bw, step_y, step_x, half, cen_y, cen_x;
		longint one, l, t, w, h, mw, mh, fw, fh, x, y, cw, ch;
		int     grid, cell_no, row, col;
		crop_t  crop;
		logit = $signed(d[15:0]);
		oy    = $signed(d[35:16]);
		ox    = $signed(d[55:36]);
		bh    = $signed(d[75:56]);
		bw    = $signed(d[95:76]);

		if (anchor_pos < abdbc_pkg::FIRST_LAYER) begin
			grid    = HI_GRID;
			cell_no = anchor_pos / HI_PER_CELL;
			row     = cell_no / HI_GRID;
			col     = cell_no % HI_GRID;
		end else begin
			grid    = LO_GRID;
			cell_no = (anchor_pos - abdbc_pkg::FIRST_LAYER) / LO_PER_CELL;
			row     = (cell_no / LO_GRID) % LO_GRID;
			col     = cell_no % LO_GRID;
		end

		if (logit > longint'(logit_floor) && (!best_seen || logit > best_logit)) begin
			step_y     = longint'(img_h) / grid;
			step_x     = longint'(img_w) / grid;
			half       = longint'(1) <<< (abdbc_pkg::FRACTION_BITS - 1);
			cen_y      = step_y * (2 * row + 1) * half;
			cen_x      = step_x * (2 * col + 1) * half;
			best_l     = saturate((ox + cen_x) - 2 * bw, BOX_W);
			best_t     = saturate((oy + cen_y) - 2 * bh, BOX_W);
			best_w     = saturate((bw * longint'(img_w)) >>> SCALE_SHIFT, BOX_W);
			best_h     = saturate((bh * longint'(img_h)) >>> SCALE_SHIFT, BOX_W);
			best_logit = logit;
			best_seen  = 1'b1;
		end

		anchor_pos = (anchor_pos + 1 >= abdbc_pkg::ANCHOR_COUNT) ? 0 : anchor_pos + 1;

		if (is_last) begin
			one = longint'(1) <<< abdbc_pkg::FRACTION_BITS;
			l   = 0;
			t   = 0;
			w   = DEFAULT_SIDE * one;
			h   = DEFAULT_SIDE * one;
			if (best_seen) begin
				l = best_l;
				t = best_t;
				w = best_w;
				h = best_h;
			end
			mw = longint'(frm_w) / MARGIN_DIV;
			mh = longint'(frm_h) / MARGIN_DIV;
			fw = longint'(frm_w);
			fh = longint'(frm_h);
			x  = trunc_px(l - mw * one);
			y  = trunc_px(t - mh * one);
			cw = trunc_px(w + 2 * mw * one);
			ch = trunc_px(h + 2 * mh * one);
			if (x < 0)
				x = 0;
			if (y < 0)
				y = 0;
			if (cw + x > fw)
				cw = fw - x;
			if (ch + y > fh)
				ch = fh - y;
			crop.x     = saturate(x, CROP_W);
			crop.y     = saturate(y, CROP_W);
			crop.w     = saturate(cw, CROP_W);
			crop.h     = saturate(ch, CROP_W);
			crop.found = best_seen;
			crop_queue.insert(crop_queue.size(), crop);
			clear_best();
		end
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_crop();
		crop_t want;
		if (crop_queue.size() == 0) begin
			$error("crop transfer with no frame outstanding");
			mismatch_count++;
		end else begin
			want = crop_queue.pop_front();
			crops_seen++;
			check_field("crop_x", want.x, $signed(m_tdata[13:0]));
			check_field("crop_y", want.y, $signed(m_tdata[27:14]));
			check_field("crop_width", want.w, $signed(m_tdata[41:28]));
			check_field("crop_height", want.h, $signed(m_tdata[55:42]));
			check_field("face_found", want.found, m_tuser);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w          = 12'd640;
			img_h          = 12'd480;
			frm_w          = 12'd640;
			frm_h          = 12'd480;
			logit_floor    = '0;
			mismatch_count = 0;
			crops_seen     = 0;
			crop_queue.delete();
			clear_best();
		end else begin
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				absorb_anchor(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				check_crop();
		end
	end

endmodule

// File: sim/tb_anchor_box_decode_best_crop_top.sv
`timescale 1ns / 100ps

module tb_anchor_box_decode_best_crop_top;

	localparam int          PHASES       = 8;
	localparam int          SHORT_ITEMS  = 24;
	localparam int          HOLD_FRAMES  = 20;
	localparam int          DRAIN_CYCLES = 16;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          CYCLE_LIMIT  = 300000;
	localparam logic [2:0]  REG_SPARE    = 3'd5;
	localparam logic [15:0] LOGIT_MAX    = 16'h7FFF;
	localparam logic [15:0] LOGIT_MIN    = 16'h8000;
	localparam logic [19:0] FIELD_MAX    = 20'h7FFFF;
	localparam logic [19:0] FIELD_MIN    = 20'h80000;

	typedef struct packed {
		logic [19:0] box_width;
		logic [19:0] box_height;
		logic [19:0] offset_x;
		logic [19:0] offset_y;
		logic [15:0] score;
	} anchor_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;   // score_logit, offset_y, offset_x, box_height, box_width
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // crop_x, crop_y, crop_width, crop_height
	logic        m_tuser;   // face_found
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	int mismatch_count;
	int crops_seen;
	int frames_sent = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_len    = 0;
	int cycle_count = 0;

	anchor_box_decode_best_crop_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	anchor_crop_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.crops_seen     (crops_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// crop receiver, with a counted hold-off on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				m_tready <= 1'b0;
				hold_len--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	function automatic anchor_t mk_anchor(input logic [15:0] score, input logic [19:0] oy,
			input logic [19:0] ox, input logic [19:0] bh, input logic [19:0] bw);
		anchor_t a;
		a.score      = score;
		a.offset_y   = oy;
		a.offset_x   = ox;
		a.box_height = bh;
		a.box_width  = bw;
		return a;
	endfunction

	function automatic anchor_t rand_anchor();
		anchor_t a;
		a.score = 16'($urandom);
		if ($urandom_range(0, 1) == 1) begin
			a.offset_y   = 20'($urandom);
			a.offset_x   = 20'($urandom);
			a.box_height = 20'($urandom);
			a.box_width  = 20'($urandom);
		end else begin
			a.offset_y   = 20'($urandom_range(0, 16383) - 8192);
			a.offset_x   = 20'($urandom_range(0, 16383) - 8192);
			a.box_height = 20'($urandom_range(0, 32767));
			a.box_width  = 20'($urandom_range(0, 32767));
		end
		return a;
	endfunction

	task automatic send_anchor(input anchor_t a, input logic is_last);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= a;
		s_tlast  <= is_last;
		do @(posedge clk); while (!s_tready);
		if (is_last)
			frames_sent++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// only called right after a frame end transfer, so the wait below always takes time
	task automatic configure(input logic [11:0] iw, input logic [11:0] ih,
			input logic [11:0] fw, input logic [11:0] fh, input logic [15:0] thr,
			input logic [2:0] spare);
		s_tvalid <= 1'b0;
		wait (crops_seen == frames_sent);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(abdbc_pkg::REG_IMAGE_WIDTH, {4'($urandom), iw});
		write_reg(abdbc_pkg::REG_IMAGE_HEIGHT, {4'($urandom), ih});
		write_reg(abdbc_pkg::REG_FRAME_WIDTH, {4'($urandom), fw});
		write_reg(abdbc_pkg::REG_FRAME_HEIGHT, {4'($urandom), fh});
		write_reg(abdbc_pkg::REG_SCORE_THRESHOLD, thr);
		write_reg(spare, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic run_frames(input int n_items);
		int sent, len, k;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 12);
			for (k = 0; k < len; k++)
				send_anchor(rand_anchor(), k == len - 1);
			sent += len;
		end
	endtask

	// one clear winner at a chosen position, every other anchor scores lower
	task automatic run_long_frame(input int len, input int peak);
		anchor_t a;
		int      k;
		for (k = 0; k < len; k++) begin
			a = rand_anchor();
			if (k == peak)
				a.score = LOGIT_MAX;
			else if (a.score == LOGIT_MAX)
				a.score = LOGIT_MAX - 16'd1;
			send_anchor(a, k == len - 1);
		end
	endtask

	initial begin
		int ph, k, len;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= abdbc_pkg::REG_IMAGE_WIDTH;
		cfg_data  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 28;
		rx_idle_pct = 45;

		// score equal to threshold does not pass
		send_anchor(mk_anchor(16'd0, 20'd0, 20'd0, 20'd256, 20'd256), 1'b1);
		// tie keeps the earlier anchor
		send_anchor(mk_anchor(16'd1, 20'd0, 20'd0, 20'd256, 20'd256), 1'b0);
		send_anchor(mk_anchor(16'd1, 20'd512, 20'd768, 20'd4096, 20'd8192), 1'b1);
		send_anchor(mk_anchor(LOGIT_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN), 1'b0);
		send_anchor(mk_anchor(LOGIT_MAX, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN), 1'b1);
		send_anchor(mk_anchor(LOGIT_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX), 1'b1);
		send_anchor(mk_anchor(16'd100, 20'd1024, 20'hFFC00, 20'd6400, 20'd5120), 1'b0);
		send_anchor(mk_anchor(16'd200, 20'hFF800, 20'd2048, 20'd12800, 20'd9600), 1'b0);
		send_anchor(mk_anchor(16'd150, 20'd0, 20'd0, 20'd3000, 20'd3000), 1'b1);
		send_anchor(mk_anchor(16'hFFFF, 20'd0, 20'd0, 20'd256, 20'd256), 1'b1);

		for (ph = 0; ph < PHASES; ph++) begin
			tx_idle_pct = ph < 3 ? 28 : (ph < 6 ? 45 : 0);
			rx_idle_pct = ph < 3 ? 45 : (ph < 6 ? 28 : 0);
			case (ph)
				0: configure(12'd640, 12'd480, 12'd640, 12'd480, 16'd0, REG_SPARE);
				1: begin
					configure(12'd4095, 12'd4095, 12'd4095, 12'd4095, LOGIT_MIN,
						REG_SPARE + 3'd1);
					len = $urandom_range(abdbc_pkg::FIRST_LAYER + 8,
						abdbc_pkg::FIRST_LAYER + 64);
					run_long_frame(len, $urandom_range(abdbc_pkg::FIRST_LAYER, len - 1));
				end
				2: begin
					configure(12'd1, 12'd1, 12'd1, 12'd1, LOGIT_MAX, REG_SPARE + 3'd2);
					hold_len = HOLD_CYCLES;
					for (k = 0; k < HOLD_FRAMES; k++) begin
						send_anchor(rand_anchor(), 1'b0);
						send_anchor(rand_anchor(), 1'b1);
					end
				end
				3: configure(12'd0, 12'd0, 12'd0, 12'd0, 16'($urandom_range(0, 4000) - 2000),
					REG_SPARE);
				4: begin
					configure(12'd128, 12'd128, 12'd192, 12'd192, 16'h0100, REG_SPARE + 3'd1);
					run_frames(SHORT_ITEMS / 2);
					s_tvalid <= 1'b0;
					wait (crops_seen == frames_sent);
				end
				5: configure(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
					12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
					16'($urandom_range(0, 4000) - 2000), REG_SPARE + 3'd2);
				6: configure(12'd640, 12'd480, 12'd640, 12'd480, 16'($urandom_range(0, 1024)),
					REG_SPARE);
				default: configure(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
					16'($urandom), REG_SPARE + 3'd1);
			endcase
			run_frames(SHORT_ITEMS);
		end

		s_tvalid <= 1'b0;
		wait (crops_seen == frames_sent);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
